// ----- design/tandem_repeat_longest_run_core_defines.svh -----
// Assertion macros used by the checker file of the tandem repeat core.
`ifndef TANDEM_REPEAT_LONGEST_RUN_CORE_DEFINES_SVH
`define TANDEM_REPEAT_LONGEST_RUN_CORE_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define TRL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, ignored while reset is asserted.
`define TRL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Next-cycle implication that is also checked across reset.
`define TRL_ASSERT_RST(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("reset check failed");

`endif

// ----- design/trl_pkg.sv -----
// Package with sizes, register indexes and helpers of the tandem repeat core.
`default_nettype none
package trl_pkg;

  // Sizing of the pattern window and of the run counters.
  localparam int MAX_PATTERN = 8;
  localparam int COUNT_WIDTH = 16;

  // The window never looks at more than eight pattern characters.
  localparam int LEN_CAP = (MAX_PATTERN < 8) ? MAX_PATTERN : 8;
  localparam int LEN_W   = 4;
  localparam int IDX_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int FILL_W  = $clog2(MAX_PATTERN + 1);

  // Field widths of the channels.
  localparam int SYM_W = 8;
  localparam int RUN_W = 16;

  // Configuration port.
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 4;
  localparam logic CFG_IDX_PATTERN = 1'b0;
  localparam logic CFG_IDX_LENGTH  = 1'b1;
  localparam logic [LEN_W-1:0] LENGTH_RESET = 4'd4;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef logic [SYM_W-1:0]       sym_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [IDX_W-1:0]       idx_t;

endpackage
`default_nettype wire

// ----- design/trl_stream_ifs.sv -----
// Valid/ready channel interfaces for the character and result streams.
`default_nettype none
interface trl_in_if import trl_pkg::*; ();
  logic valid;
  logic ready;
  sym_t symbol;
  logic last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface trl_out_if import trl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RUN_W-1:0] longest_run;
  logic             saturated;

  modport source (output valid, output longest_run, output saturated, input ready);
  modport sink   (input valid, input longest_run, input saturated, output ready);
endinterface
`default_nettype wire

// ----- design/tandem_repeat_longest_run_core.sv -----
// Top level of the tandem repeat core: finds the longest run of pattern copies.
//
//   channel   direction  handshake         payload
//   in_ch     sink       valid/ready       symbol[7:0], last
//   out_ch    source     valid/ready       longest_run[15:0], saturated
//   cfg_*     slave      APB, pready = 1   pattern_chars @0x0, pattern_length @0x8
//
// One character per cycle while no last character waits on the result register: a request
// lands in the input register, and the window compare and one run counter update retire it.
// A last character needs a free result register; others never wait on it.
// Reset is synchronous, active low, and clears all sequence state at once.
// A stalled result holds in the output register while characters keep flowing.
`default_nettype none
module tandem_repeat_longest_run_core import trl_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  trl_in_if.sink                     in_ch,
  trl_out_if.source                  out_ch,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  // Configuration registers.
  logic [63:0]      pat_chars_r;
  logic [LEN_W-1:0] pat_len_r;

  // Input register.
  logic s1_valid_r;
  sym_t s1_sym_r;
  logic s1_last_r;

  // Sequence state.
  sym_t              hist_r [MAX_PATTERN];
  logic [FILL_W-1:0] fill_r;
  count_t            runs_r [MAX_PATTERN];
  idx_t              phase_r;
  count_t            best_r;
  logic              sat_r;

  // Result register.
  logic             out_valid_r;
  logic [RUN_W-1:0] out_run_r;
  logic             out_sat_r;

  // Next values.
  sym_t              hist_nxt [MAX_PATTERN];
  logic [FILL_W-1:0] fill_nxt;
  idx_t              phase_nxt;
  count_t            run_nxt;
  count_t            best_nxt;
  logic              sat_nxt;

  logic             out_free;
  logic             s1_fire;
  logic [LEN_W-1:0] eff_len;
  logic             match;
  idx_t             ph;
  count_t           run_inc;
  logic [31:0]      best_ext;
  logic             best_over;
  logic [RUN_W-1:0] res_run;
  logic             res_sat;
  logic             cfg_wr;

  // Handshake: the input register drains unless a last character meets a full output.
  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && (!s1_last_r || out_free);
  assign in_ch.ready = !s1_valid_r || s1_fire;

  // Effective pattern length: zero acts as one, large values are capped.
  always_comb begin
    if (pat_len_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (int'(pat_len_r) > LEN_CAP) begin
      eff_len = LEN_W'(LEN_CAP);
    end else begin
      eff_len = pat_len_r;
    end
  end

  // Shift the new character into the window and count the fill.
  always_comb begin
    hist_nxt[0] = s1_sym_r;
    for (int j = 1; j < MAX_PATTERN; j++) begin
      hist_nxt[j] = hist_r[j-1];
    end
    fill_nxt = (int'(fill_r) < MAX_PATTERN) ? fill_r + FILL_W'(1) : fill_r;
  end

  // Window compare: pattern character k against the k-th oldest in the window.
  always_comb begin
    match = (int'(fill_nxt) >= int'(eff_len));
    for (int k = 0; k < LEN_CAP; k++) begin
      if (k < int'(eff_len)) begin
        if (pat_chars_r[8*k +: 8] != hist_nxt[IDX_W'(eff_len - LEN_W'(k) - LEN_W'(1))]) begin
          match = 1'b0;
        end
      end
    end
  end

  // Run counter of the current phase, best run and phase advance.
  always_comb begin
    ph       = (int'(phase_r) >= MAX_PATTERN) ? '0 : phase_r;
    run_inc  = (runs_r[ph] < COUNT_MAX) ? runs_r[ph] + COUNT_WIDTH'(1) : runs_r[ph];
    run_nxt  = match ? run_inc : '0;
    sat_nxt  = sat_r || (match && (run_inc == COUNT_MAX));
    best_nxt = (match && (run_inc > best_r)) ? run_inc : best_r;
    if (int'(ph) + 1 >= int'(eff_len)) begin
      phase_nxt = '0;
    end else begin
      phase_nxt = ph + IDX_W'(1);
    end
  end

  // Result: a best run beyond the output width reads as all ones and saturated.
  always_comb begin
    best_ext  = 32'(best_nxt);
    best_over = (best_ext > 32'hFFFF);
    res_run   = best_over ? '1 : best_ext[RUN_W-1:0];
    res_sat   = sat_nxt || best_over;
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      s1_sym_r  <= in_ch.symbol;
      s1_last_r <= in_ch.last;
    end
  end

  // Sequence state: update on each retired character, clear after the last.
  always_ff @(posedge clk) begin
    if (!rst_n || (s1_fire && s1_last_r)) begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
        hist_r[j] <= '0;
        runs_r[j] <= '0;
      end
      fill_r  <= '0;
      phase_r <= '0;
      best_r  <= '0;
      sat_r   <= 1'b0;
    end else if (s1_fire) begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
        hist_r[j] <= hist_nxt[j];
      end
      runs_r[ph] <= run_nxt;
      fill_r     <= fill_nxt;
      phase_r    <= phase_nxt;
      best_r     <= best_nxt;
      sat_r      <= sat_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_fire && s1_last_r) begin
      out_run_r <= res_run;
      out_sat_r <= res_sat;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.longest_run = out_run_r;
  assign out_ch.saturated   = out_sat_r;

  // Configuration port: register index sits at address bit 3.
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_chars_r <= '0;
      pat_len_r   <= LENGTH_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[3])
        CFG_IDX_PATTERN: pat_chars_r <= cfg_pwdata;
        CFG_IDX_LENGTH:  pat_len_r   <= cfg_pwdata[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3])
      CFG_IDX_PATTERN: cfg_prdata = pat_chars_r;
      CFG_IDX_LENGTH:  cfg_prdata = CFG_DATA_W'(pat_len_r);
      default:         cfg_prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- design/trl_checker.sv -----
// Port-level checker of the tandem repeat core and its bind statement.
`default_nettype none
`include "tandem_repeat_longest_run_core_defines.svh"
module trl_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_longest_run,
  input wire logic        out_saturated
);

  // A result waiting to be taken stays offered.
  `TRL_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // With the result register empty, nothing can stall the character stream.
  `TRL_ASSERT_IMP(a_in_free, clk, rst_n, !out_valid, in_ready)

  // A run count at the top of the output range always comes with the flag.
  `TRL_ASSERT_IMP(a_full_sat, clk, rst_n, out_valid && (out_longest_run == 16'hFFFF),
                  out_saturated)

  // Reset drops any pending result.
  `TRL_ASSERT_RST(a_rst_clear, clk, !rst_n, !out_valid)

  // A character request that is not taken stays offered.
  `TRL_ASSERT_NXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid)

endmodule

bind tandem_repeat_longest_run_core trl_checker u_trl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_longest_run (out_ch.longest_run),
  .out_saturated   (out_ch.saturated)
);
`default_nettype wire
